// File: rtl/k_mismatch_pattern_counter_top_assert.svh
// Assertion macros shared by the k-mismatch counter RTL.
`ifndef K_MISMATCH_PATTERN_COUNTER_TOP_ASSERT_SVH
`define K_MISMATCH_PATTERN_COUNTER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KMPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/kmpc_pkg.sv
// Shared constants, types and helpers of the k-mismatch counter.
package kmpc_pkg;

    localparam int unsigned MAX_PATTERN = 256;
    localparam int unsigned MAX_TEXT    = 65536;

    localparam int unsigned SYM_W     = 8;
    localparam int unsigned MM_W      = 3;
    localparam int unsigned CAP_W     = MM_W + 1;
    localparam int unsigned PAT_LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int unsigned CNT_W     = $clog2(MAX_TEXT + 1);

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    localparam logic [MM_W-1:0]      MM_RESET     = MM_W'(3);
    localparam logic [CAP_W-1:0]     MISMATCH_CAP = CAP_W'(2 ** MM_W);
    localparam logic [PAT_LEN_W-1:0] PAT_CAP      = PAT_LEN_W'(MAX_PATTERN);
    localparam logic [CNT_W-1:0]     TEXT_CAP     = CNT_W'(MAX_TEXT);

    typedef logic [SYM_W-1:0]     t_sym;
    typedef logic [CAP_W-1:0]     t_mm_cnt;
    typedef logic [PAT_LEN_W-1:0] t_plen;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef struct packed {
        logic              pat_wr;
        logic              txt_step;
        logic              flush;
        t_plen             pat_len;
        t_sym              sym;
        logic [MM_W-1:0]   max_mm;
    } t_chain_ctl;

    function automatic t_plen to_plen(input int unsigned v);
        return v[PAT_LEN_W-1:0];
    endfunction

endpackage

// File: rtl/kmpc_cell.sv
// One pattern cell: pattern symbol and mismatch count of one alignment.
module kmpc_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  kmpc_pkg::t_chain_ctl     i_ctl,
    input  logic                     i_wr_sel,
    input  logic                     i_tail,
    input  kmpc_pkg::t_mm_cnt        i_prev_cnt,
    input  logic                     i_prev_valid,
    output kmpc_pkg::t_mm_cnt        o_cnt,
    output logic                     o_valid,
    output logic                     o_hit
);

    kmpc_pkg::t_sym    r_sym;
    kmpc_pkg::t_mm_cnt r_cnt;
    logic              r_valid;
    kmpc_pkg::t_mm_cnt n_cnt;

    always_comb begin
        n_cnt = i_prev_cnt;
        if (i_ctl.sym != r_sym && i_prev_cnt < kmpc_pkg::MISMATCH_CAP) begin
            n_cnt = i_prev_cnt + kmpc_pkg::t_mm_cnt'(1);
        end
    end

    assign o_hit = i_ctl.txt_step & i_tail & i_prev_valid
                 & (n_cnt <= {1'b0, i_ctl.max_mm});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.flush) begin
            r_valid <= 1'b0;
        end else if (i_ctl.txt_step) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pat_wr && i_wr_sel) begin
            r_sym <= i_ctl.sym;
        end
        if (i_ctl.txt_step) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt   = r_cnt;
    assign o_valid = r_valid;

endmodule

// File: rtl/kmpc_chain.sv
// Row of pattern cells; alignments shift one cell per text symbol.
module kmpc_chain (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kmpc_pkg::t_chain_ctl  i_ctl,
    output logic                  o_hit
);

    kmpc_pkg::t_mm_cnt w_cnt   [kmpc_pkg::MAX_PATTERN];
    logic              w_valid [kmpc_pkg::MAX_PATTERN];
    logic [kmpc_pkg::MAX_PATTERN-1:0] w_hit;

    for (genvar k = 0; k < kmpc_pkg::MAX_PATTERN; k++) begin : g_cell
        kmpc_pkg::t_mm_cnt w_prev_cnt;
        logic              w_prev_valid;

        if (k == 0) begin : g_head
            assign w_prev_cnt   = '0;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_cnt   = w_cnt[k-1];
            assign w_prev_valid = w_valid[k-1];
        end

        kmpc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_wr_sel     (i_ctl.pat_len == kmpc_pkg::to_plen(k)),
            .i_tail       (i_ctl.pat_len == kmpc_pkg::to_plen(k + 1)),
            .i_prev_cnt   (w_prev_cnt),
            .i_prev_valid (w_prev_valid),
            .o_cnt        (w_cnt[k]),
            .o_valid      (w_valid[k]),
            .o_hit        (w_hit[k])
        );
    end

    assign o_hit = |w_hit;

endmodule

// File: rtl/k_mismatch_pattern_counter_top.sv
// Top level of the k-mismatch pattern counter: control, counters, result register.
//
//  channel   direction  handshake                     payload
//  input     in         i_valid / o_stall             i_operation, i_symbol, i_last
//  result    out        o_valid / i_stall             o_match_count
//  config    in         i_cfg_valid / o_cfg_ready     i_cfg_data
//
// One request per cycle while o_stall is low; each text symbol updates every cell of the chain at once.
// The count appears in the result register the cycle after the final text symbol.
// The longest path is a cell compare, the OR over all cell hits and the count add.
// Synchronous active-low reset clears control state and sets max_mismatches to 3.
// Input stalls only while a result waits and the output side stalls.
`include "k_mismatch_pattern_counter_top_assert.svh"

module k_mismatch_pattern_counter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_operation,
    input  logic [kmpc_pkg::SYM_W-1:0]     i_symbol,
    input  logic                           i_last,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [kmpc_pkg::CNT_W-1:0]     o_match_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kmpc_pkg::MM_W-1:0]      i_cfg_data
);

    logic [kmpc_pkg::MM_W-1:0] r_max_mm;
    kmpc_pkg::t_plen           r_pat_len;
    kmpc_pkg::t_plen           n_pat_len;
    logic                      r_pat_done;
    logic                      n_pat_done;
    kmpc_pkg::t_cnt            r_run;
    kmpc_pkg::t_cnt            n_run;
    kmpc_pkg::t_cnt            r_pos;
    kmpc_pkg::t_cnt            n_pos;
    logic                      r_out_valid;
    logic                      n_out_valid;
    kmpc_pkg::t_cnt            r_out_data;
    kmpc_pkg::t_cnt            n_result;

    logic                      w_in_acc;
    logic                      w_pat_wr;
    logic                      w_step;
    logic                      w_flush;
    logic                      w_hit;
    kmpc_pkg::t_chain_ctl      w_ctl;

    assign o_stall     = r_out_valid & i_stall;
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid & ~o_stall;
    assign w_step      = w_in_acc & (i_operation == kmpc_pkg::OP_TEXT);
    assign w_pat_wr    = w_in_acc & (i_operation == kmpc_pkg::OP_PATTERN) & ~r_pat_done
                       & (r_pat_len < kmpc_pkg::PAT_CAP);
    assign w_flush     = w_step & i_last;

    always_comb begin
        w_ctl          = '0;
        w_ctl.pat_wr   = w_pat_wr;
        w_ctl.txt_step = w_step;
        w_ctl.flush    = w_flush;
        w_ctl.pat_len  = r_pat_len;
        w_ctl.sym      = i_symbol;
        w_ctl.max_mm   = r_max_mm;
    end

    kmpc_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_hit   (w_hit)
    );

    always_comb begin
        n_pat_len  = r_pat_len;
        n_pat_done = r_pat_done;
        n_run      = r_run;
        n_pos      = r_pos;
        if (w_pat_wr) begin
            n_pat_len = r_pat_len + kmpc_pkg::t_plen'(1);
        end
        if (w_in_acc && (i_last || i_operation == kmpc_pkg::OP_TEXT)) begin
            n_pat_done = 1'b1;
        end
        if (w_step && w_hit && r_run < kmpc_pkg::TEXT_CAP) begin
            n_run = r_run + kmpc_pkg::t_cnt'(1);
        end
        if (w_step && r_pos < kmpc_pkg::TEXT_CAP) begin
            n_pos = r_pos + kmpc_pkg::t_cnt'(1);
        end
        if (r_pat_len != '0) begin
            n_result = n_run;
        end else if (n_pos >= kmpc_pkg::TEXT_CAP) begin
            n_result = kmpc_pkg::TEXT_CAP;
        end else begin
            n_result = n_pos + kmpc_pkg::t_cnt'(1);
        end
        n_out_valid = r_out_valid & i_stall;
        if (w_flush) begin
            n_out_valid = 1'b1;
            n_pat_len   = '0;
            n_pat_done  = 1'b0;
            n_run       = '0;
            n_pos       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_mm    <= kmpc_pkg::MM_RESET;
            r_pat_len   <= '0;
            r_pat_done  <= 1'b0;
            r_run       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_mm <= i_cfg_data;
            end
            r_pat_len   <= n_pat_len;
            r_pat_done  <= n_pat_done;
            r_run       <= n_run;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_flush) begin
            r_out_data <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_match_count = r_out_data;

    `KMPC_ASSERT_NOW(a_count_bound, o_valid, o_match_count <= kmpc_pkg::TEXT_CAP, "count above cap")
    `KMPC_ASSERT_NEXT(a_flush_clears, w_flush, r_pat_len == '0 && !r_pat_done && r_run == '0, "case not cleared")
    `KMPC_ASSERT_NEXT(a_result_source, !o_valid, !o_valid || $past(w_flush), "result without final text")
    `KMPC_ASSERT_NEXT(a_pattern_frozen, r_pat_done, r_pat_len == $past(r_pat_len) || r_pat_len == '0, "pattern grew after close")

endmodule

// File: test/tb_top.sv
// Testbench for the k-mismatch pattern counter: directed and random cases against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kmpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_ITEMS  = 800;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned REPORT_LIMIT  = 10;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_operation = OP_PATTERN;
    t_sym              i_symbol = '0;
    logic              i_last = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    t_cnt              o_match_count;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [MM_W-1:0]   i_cfg_data = '0;

    k_mismatch_pattern_counter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_symbol      (i_symbol),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_match_count (o_match_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5ns i_clk = ~i_clk;

    // predictor state
    t_sym              pat_mem [MAX_PATTERN];
    int unsigned       pat_len;
    bit                pat_closed;
    t_mm_cnt           align_mm [MAX_PATTERN];
    longint unsigned   txt_pos;
    int unsigned       hits;
    logic [MM_W-1:0]   mm_limit;

    t_cnt              expected_counts[$];

    int unsigned       cycle_count;
    int unsigned       mismatch_total;
    int unsigned       useful_items;
    int unsigned       counts_checked;
    int unsigned       limit_writes;
    t_cnt              largest_count;

    int unsigned       gap_max = 0;
    int unsigned       burst_max = 1;
    int unsigned       burst_left = 0;
    int unsigned       stall_pct = 0;
    bit                stall_periodic = 1'b0;
    int unsigned       stall_phase = 0;

    function automatic void clear_case();
        pat_len    = 0;
        pat_closed = 1'b0;
        txt_pos    = 0;
        hits       = 0;
        foreach (align_mm[i]) align_mm[i] = '0;
    endfunction

    task automatic predict_match_count(input logic op, input t_sym sym, input logic last,
                                       output bit took_effect, output bit has_count,
                                       output t_cnt count);
        int unsigned     k;
        int unsigned     slot;
        t_mm_cnt         mm;
        longint unsigned total;
        took_effect = 1'b1;
        has_count   = 1'b0;
        count       = '0;
        if (op == OP_PATTERN) begin
            took_effect = !pat_closed;
            if (!pat_closed) begin
                if (pat_len < MAX_PATTERN) begin
                    pat_mem[pat_len] = sym;
                    pat_len++;
                end
                if (last) pat_closed = 1'b1;
            end
            return;
        end
        pat_closed = 1'b1;
        for (k = 0; k < pat_len && k <= txt_pos; k++) begin
            slot = (txt_pos - k) % MAX_PATTERN;
            mm = (k == 0) ? t_mm_cnt'(0) : align_mm[slot];
            if (sym != pat_mem[k] && mm < MISMATCH_CAP) mm++;
            align_mm[slot] = mm;
            if (k == pat_len - 1 && mm <= {1'b0, mm_limit} && hits < MAX_TEXT) hits++;
        end
        txt_pos++;
        if (last) begin
            has_count = 1'b1;
            if (pat_len == 0) begin
                total = txt_pos + 1;
                if (total > MAX_TEXT) total = MAX_TEXT;
            end else begin
                total = hits;
            end
            count = t_cnt'(total);
            clear_case();
        end
    endtask

    task automatic note_failure(input string what, input t_cnt want, input t_cnt got);
        mismatch_total++;
        if (mismatch_total <= REPORT_LIMIT)
            $display("%0t: %s: expected %0d, actual %0d", $realtime, what, want, got);
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (stall_periodic) begin
            i_stall <= (stall_phase % 9) < 4;
        end else begin
            i_stall <= $urandom_range(99) < stall_pct;
        end
        stall_phase++;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_counts.size() == 0) begin
                note_failure("unexpected match count", '0, o_match_count);
            end else begin
                if (o_match_count !== expected_counts[0])
                    note_failure("match_count", expected_counts[0], o_match_count);
                if (expected_counts[0] > largest_count) largest_count = expected_counts[0];
                void'(expected_counts.pop_front());
                counts_checked++;
            end
        end
    end

    task automatic send_request(input logic op, input t_sym sym, input logic last);
        int unsigned gap;
        bit          took, has_count;
        t_cnt        count;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_symbol    <= sym;
        i_last      <= last;
        do @(posedge i_clk); while (o_stall);
        predict_match_count(op, sym, last, took, has_count, count);
        if (took) useful_items++;
        if (has_count) expected_counts.push_back(count);
    endtask

    task automatic send_pattern(input t_sym syms[$], input bit close);
        foreach (syms[i]) send_request(OP_PATTERN, syms[i], close && i == syms.size() - 1);
    endtask

    task automatic send_text(input t_sym syms[$], input bit close);
        foreach (syms[i]) send_request(OP_TEXT, syms[i], close && i == syms.size() - 1);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_counts.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mismatch_limit(input logic [MM_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        mm_limit = value;
        limit_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned profile);
        case (profile)
            0: begin
                gap_max = 0; burst_max = 1; stall_pct = 0; stall_periodic = 0;
            end
            1: begin
                gap_max = 3; burst_max = 8; stall_pct = 30; stall_periodic = 0;
            end
            2: begin
                gap_max = 1; burst_max = 4; stall_pct = 0; stall_periodic = 1;
            end
            default: begin
                gap_max = 6; burst_max = 3; stall_pct = 70; stall_periodic = 0;
            end
        endcase
        burst_left = 0;
    endtask

    task automatic test_basic_cases();
        write_mismatch_limit(MM_RESET);
        set_idling(1);
        send_pattern('{8'h00, 8'hFF}, 1);
        send_text('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00}, 1);
        // empty pattern
        send_text('{8'h5A, 8'hA5, 8'h00}, 1);
        // pattern longer than text
        send_pattern('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05}, 1);
        send_text('{8'h01, 8'h02}, 1);
        // text closes an open pattern
        send_pattern('{8'h80, 8'h7F}, 0);
        send_text('{8'h80, 8'h7F, 8'h80}, 1);
        // pattern symbol after close is dropped
        send_pattern('{8'h11}, 1);
        send_pattern('{8'h22}, 0);
        send_text('{8'h11, 8'h22, 8'h11}, 1);
        drain();
    endtask

    task automatic test_mismatch_limits();
        t_sym pat[$];
        t_sym txt[$];
        for (int i = 0; i < 12; i++) begin
            pat.push_back(8'h55);
            txt.push_back(i < 7 ? 8'hAA : 8'h55);
        end
        set_idling(2);
        write_mismatch_limit(3'd0);
        send_pattern('{8'h33, 8'h44}, 1);
        send_text('{8'h33, 8'h44, 8'h33, 8'h45, 8'h33, 8'h44}, 1);
        drain();
        write_mismatch_limit(3'd7);
        send_pattern(pat, 1);
        send_text(txt, 1);
        send_pattern(pat, 1);
        foreach (txt[i]) txt[i] = 8'hAA;
        send_text(txt, 1);
        drain();
    endtask

    task automatic test_limit_change_mid_case();
        set_idling(1);
        write_mismatch_limit(3'd2);
        send_pattern('{8'h10, 8'h20, 8'h30, 8'h40}, 1);
        send_text('{8'h10, 8'h21, 8'h31, 8'h40, 8'h10}, 0);
        drain();
        write_mismatch_limit(3'd1);
        send_text('{8'h20, 8'h31, 8'h41, 8'h10}, 0);
        drain();
        write_mismatch_limit(3'd2);
        send_text('{8'h20, 8'h30, 8'h41}, 1);
        drain();
    endtask

    task automatic test_pattern_overflow();
        t_sym pat[$];
        t_sym txt[$];
        for (int i = 0; i < MAX_PATTERN + 4; i++) pat.push_back(t_sym'(i));
        for (int i = 0; i < 300; i++) txt.push_back(t_sym'(i));
        set_idling(0);
        write_mismatch_limit(3'd7);
        send_pattern(pat, 1);
        send_text(txt, 1);
        drain();
    endtask

    function automatic t_sym pick_symbol(input bit narrow, input t_sym base);
        return narrow ? (base ^ t_sym'($urandom_range(3))) : t_sym'($urandom_range(255));
    endfunction

    task automatic test_random_cases();
        t_sym        pat[$];
        t_sym        txt[$];
        t_sym        head[$];
        t_sym        base;
        bit          narrow;
        int unsigned plen, tlen, off, pick, cases, start;
        logic [MM_W-1:0] limit;
        cases = 0;
        start = useful_items;
        while (useful_items - start < RANDOM_ITEMS) begin
            if (cases % 12 == 0) begin
                drain();
                pick = $urandom_range(3);
                limit = (pick == 0) ? 3'd0 : (pick == 1) ? 3'd7 : 3'($urandom_range(7));
                write_mismatch_limit(limit);
                set_idling($urandom_range(3));
            end
            cases++;
            pick = $urandom_range(99);
            plen = (pick < 10) ? 0 : (pick < 80) ? $urandom_range(1, 8) :
                   (pick < 96) ? $urandom_range(9, 40) : $urandom_range(200, MAX_PATTERN + 6);
            narrow = $urandom_range(9) < 7;
            base = t_sym'($urandom_range(255));
            pat.delete();
            txt.delete();
            for (int i = 0; i < plen; i++) pat.push_back(pick_symbol(narrow, base));
            tlen = (plen > 40) ? $urandom_range(plen - 10, plen + 40) :
                   $urandom_range(1, 3 * plen + 10);
            off = $urandom_range(7);
            for (int i = 0; i < tlen; i++) begin
                if (plen != 0 && $urandom_range(99) < 80) txt.push_back(pat[(i + off) % plen]);
                else txt.push_back(pick_symbol(narrow, base));
            end
            pick = $urandom_range(99);
            if (pick < 85) begin
                send_pattern(pat, 1);
                send_text(txt, 1);
            end else if (pick < 90) begin
                send_pattern(pat, 0);
                send_text(txt, 1);
            end else if (pick < 95) begin
                send_pattern(pat, 1);
                send_pattern('{pick_symbol(0, base), pick_symbol(0, base)}, 1);
                send_text(txt, 1);
            end else begin
                send_pattern(pat, 1);
                head = txt[0:(tlen - 1) / 2];
                send_text(head, 0);
                txt = txt[((tlen - 1) / 2 + 1):$];
                if (txt.size() == 0) txt.push_back(pick_symbol(narrow, base));
                send_text(txt, 1);
            end
        end
        drain();
    endtask

    initial begin
        clear_case();
        mm_limit = MM_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_cases();
        test_mismatch_limits();
        test_limit_change_mid_case();
        test_pattern_overflow();
        test_random_cases();
        drain();
        $display("covered %0d requests, %0d match counts checked, largest count %0d",
                 useful_items, counts_checked, largest_count);
        $display("mismatch limit written %0d times, %0d mismatches", limit_writes,
                 mismatch_total);
        if (mismatch_total == 0 && expected_counts.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
